/* hdl/bdpa_pkg.sv */
// ----------------------------------------------------------------------------
// bdpa_pkg: shared types and constants
// Lane count, queue sizing, the queued word layout and FP32 constants used
// by the front end, the queue and the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

package bdpa_pkg;

  localparam int LANES = 16;
  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int RLEN_W = 17;
  localparam logic [RLEN_W-1:0] REDUCE_LEN_RESET = 17'd4096;

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [30:0] INF_MAG = 31'h7F80_0000;

  // Operand classes.
  typedef logic [1:0] fclass_t;
  localparam fclass_t CL_ZERO = 2'd0;
  localparam fclass_t CL_NORM = 2'd1;
  localparam fclass_t CL_INF  = 2'd2;
  localparam fclass_t CL_NAN  = 2'd3;

  // One queued word: activations already masked by the reduction length.
  typedef struct packed {
    logic [15:0] act_lo;
    logic [15:0] act_hi;
    logic [15:0] wgt_lo;
    logic [15:0] wgt_hi;
    logic [3:0]  lane;
    logic        first;
    logic        last;
  } item_t;

endpackage

`default_nettype wire

/* hdl/bdpa_front.sv */
// ----------------------------------------------------------------------------
// bdpa_front: input acceptance and masking
// Holds the reduction length register, masks activations at or beyond it
// and pushes the word into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpa_front
  import bdpa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [RLEN_W-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [15:0]       act_lo,
  input  wire logic [15:0]       act_hi,
  input  wire logic [15:0]       wgt_lo,
  input  wire logic [15:0]       wgt_hi,
  input  wire logic [3:0]        lane,
  input  wire logic [15:0]       pos,
  input  wire logic              first,
  input  wire logic              last,
  input  wire logic              q_full,
  output logic                   q_push,
  output item_t                  q_item
);

  logic [RLEN_W-1:0] reduce_len;
  logic [RLEN_W-1:0] pos_lo;
  logic [RLEN_W-1:0] pos_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      reduce_len <= REDUCE_LEN_RESET;
    end else if (cfg_we) begin
      reduce_len <= cfg_data;
    end
  end

  assign pos_lo = {1'b0, pos};
  assign pos_hi = pos_lo + 17'd1;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.act_lo = (pos_lo >= reduce_len) ? 16'd0 : act_lo;
    q_item.act_hi = (pos_hi >= reduce_len) ? 16'd0 : act_hi;
    q_item.wgt_lo = wgt_lo;
    q_item.wgt_hi = wgt_hi;
    q_item.lane   = lane;
    q_item.first  = first;
    q_item.last   = last;
  end

endmodule

`default_nettype wire

/* hdl/bdpa_queue.sv */
// ----------------------------------------------------------------------------
// bdpa_queue: short word queue between front and back end
// A small register FIFO so that either side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpa_queue
  import bdpa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  item_t     push_item,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output item_t     head
);

  item_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/bdpa_back.sv */
// ----------------------------------------------------------------------------
// bdpa_back: lane accumulators and the shared multiply-add sequencer
// Runs the high and then the low product of one word through a four-step
// multiply, align and add, normalize, round sequence and reports sums.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpa_back
  import bdpa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_empty,
  input  item_t      q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output logic [3:0] out_lane,
  output logic [31:0] sum_bits
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_ALN  = 6'b000100,
    ST_NRM  = 6'b001000,
    ST_RND  = 6'b010000,
    ST_WB   = 6'b100000
  } state_t;

  state_t              state;
  item_t               cur;
  logic                op;
  logic [31:0]         acc;
  logic [31:0]         lane_acc [LANES];
  logic [LANE_W-1:0]   head_idx;
  logic [LANE_W-1:0]   cur_idx;

  // Multiply step registers.
  logic [15:0]         mp;
  logic signed [11:0]  xp;
  logic                sp;
  logic                sc;
  logic [23:0]         mc;
  logic [7:0]          ec;
  logic                prod_only;

  // Add and normalize step registers.
  logic [41:0]         r;
  logic signed [11:0]  e;
  logic                s;
  logic [5:0]          lz;

  assign head_idx = q_head.lane[LANE_W-1:0];
  assign cur_idx  = cur.lane[LANE_W-1:0];
  assign q_pop    = (state == ST_IDLE) && !q_empty;

  // ---------------- multiply and classify ----------------
  logic [15:0]  a_op;
  logic [15:0]  w_op;
  fclass_t      pc;
  fclass_t      cc;
  logic         m_special;
  logic [31:0]  m_value;
  logic         m_sp;

  always_comb begin
    logic [7:0] ea;
    logic [7:0] ew;
    logic [7:0] eca;
    a_op = op ? cur.act_lo : cur.act_hi;
    w_op = op ? cur.wgt_lo : cur.wgt_hi;
    ea   = a_op[14:7];
    ew   = w_op[14:7];
    eca  = acc[30:23];
    m_sp = a_op[15] ^ w_op[15];
    if ((ea == 8'hFF && a_op[6:0] != 7'd0) || (ew == 8'hFF && w_op[6:0] != 7'd0) ||
        (ea == 8'hFF && ew == 8'd0) || (ew == 8'hFF && ea == 8'd0)) begin
      pc = CL_NAN;
    end else if (ea == 8'hFF || ew == 8'hFF) begin
      pc = CL_INF;
    end else if (ea == 8'd0 || ew == 8'd0) begin
      pc = CL_ZERO;
    end else begin
      pc = CL_NORM;
    end
    if (eca == 8'hFF) begin
      cc = (acc[22:0] != 23'd0) ? CL_NAN : CL_INF;
    end else if (eca == 8'd0) begin
      cc = CL_ZERO;
    end else begin
      cc = CL_NORM;
    end
    m_special = 1'b1;
    m_value   = acc;
    if (pc == CL_NAN || cc == CL_NAN) begin
      m_value = QNAN_BITS;
    end else if (pc == CL_INF && cc == CL_INF) begin
      m_value = (m_sp == acc[31]) ? acc : QNAN_BITS;
    end else if (pc == CL_INF) begin
      m_value = {m_sp, INF_MAG};
    end else if (cc == CL_INF) begin
      m_value = acc;
    end else if (pc == CL_ZERO) begin
      m_value = (cc == CL_ZERO) ? {m_sp & acc[31], 31'd0} : acc;
    end else begin
      m_special = 1'b0;
    end
  end

  // ---------------- align and add ----------------
  logic [41:0]        a_r;
  logic signed [11:0] a_e;
  logic               a_s;
  logic               a_zero;

  always_comb begin
    logic [40:0]        mpn;
    logic [40:0]        mcn;
    logic signed [11:0] xpn;
    logic signed [11:0] xcn;
    logic [40:0]        mx;
    logic [40:0]        my;
    logic [40:0]        shifted;
    logic [40:0]        my_al;
    logic signed [11:0] ex;
    logic signed [11:0] ey;
    logic signed [11:0] d;
    logic               sx;
    logic               sy;
    logic               c_big;
    mpn = mp[15] ? ({25'd0, mp} << 25) : ({25'd0, mp} << 26);
    xpn = mp[15] ? (xp - 12'sd25) : (xp - 12'sd26);
    mcn = {mc, 17'd0};
    xcn = $signed({4'd0, ec}) - 12'sd167;
    c_big = (xcn > xpn) || (xcn == xpn && mcn >= mpn);
    mx = c_big ? mcn : mpn;
    my = c_big ? mpn : mcn;
    ex = c_big ? xcn : xpn;
    ey = c_big ? xpn : xcn;
    sx = c_big ? sc : sp;
    sy = c_big ? sp : sc;
    d  = ex - ey;
    shifted = my >> d[5:0];
    if (d > 12'sd41) begin
      my_al = 41'd1;
    end else begin
      my_al = shifted | {40'd0, ((shifted << d[5:0]) != my)};
    end
    a_zero = 1'b0;
    a_s    = sx;
    a_e    = ex;
    if (prod_only) begin
      a_r = {26'd0, mp};
      a_e = xp;
      a_s = sp;
    end else if (sx == sy) begin
      a_r = {1'b0, mx} + {1'b0, my_al};
    end else begin
      a_r = {1'b0, mx} - {1'b0, my_al};
      a_zero = (mx == my_al);
    end
  end

  // ---------------- leading zero count ----------------
  logic [5:0] n_lz;

  always_comb begin
    n_lz = 6'd0;
    for (int i = 0; i < 42; i++) begin
      if (r[i]) begin
        n_lz = 6'(41 - i);
      end
    end
  end

  // ---------------- round and pack ----------------
  logic [31:0] rnd_value;

  always_comb begin
    logic [41:0]        rn;
    logic [23:0]        q;
    logic [24:0]        qr;
    logic               inc;
    logic signed [11:0] be;
    rn  = r << lz;
    q   = rn[41:18];
    inc = rn[17] && ((|rn[16:0]) || q[0]);
    qr  = {1'b0, q} + {24'd0, inc};
    be  = e + 12'sd168 - $signed({6'd0, lz}) + $signed({11'd0, qr[24]});
    if (be >= 12'sd255) begin
      rnd_value = {s, INF_MAG};
    end else if (be <= 12'sd0) begin
      rnd_value = {s, 31'd0};
    end else begin
      rnd_value = {s, be[7:0], (qr[24] ? 23'd0 : qr[22:0])};
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      op        <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        lane_acc[i] <= 32'd0;
      end
    end else begin
      // A finishing last word reloads the output register itself below.
      if (out_valid && !out_stall && !(state == ST_WB && cur.last)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            cur   <= q_head;
            acc   <= q_head.first ? 32'd0 : lane_acc[head_idx];
            op    <= 1'b0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          mp        <= {1'b1, a_op[6:0]} * {1'b1, w_op[6:0]};
          xp        <= $signed({4'd0, a_op[14:7]}) + $signed({4'd0, w_op[14:7]})
                       - 12'sd268;
          sp        <= m_sp;
          sc        <= acc[31];
          mc        <= {1'b1, acc[22:0]};
          ec        <= acc[30:23];
          prod_only <= (cc == CL_ZERO);
          if (m_special) begin
            acc <= m_value;
            if (op) begin
              state <= ST_WB;
            end else begin
              op <= 1'b1;
            end
          end else begin
            state <= ST_ALN;
          end
        end
        ST_ALN: begin
          r <= a_r;
          e <= a_e;
          s <= a_s;
          if (a_zero) begin
            acc <= 32'd0;
            if (op) begin
              state <= ST_WB;
            end else begin
              op    <= 1'b1;
              state <= ST_MUL;
            end
          end else begin
            state <= ST_NRM;
          end
        end
        ST_NRM: begin
          lz    <= n_lz;
          state <= ST_RND;
        end
        ST_RND: begin
          acc <= rnd_value;
          if (op) begin
            state <= ST_WB;
          end else begin
            op    <= 1'b1;
            state <= ST_MUL;
          end
        end
        ST_WB: begin
          if (!(cur.last && out_valid && out_stall)) begin
            lane_acc[cur_idx] <= acc;
            if (cur.last) begin
              out_valid <= 1'b1;
              out_lane  <= 4'(cur_idx);
              sum_bits  <= acc;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/bf16_dot_product_accumulator_top.sv */
// ----------------------------------------------------------------------------
// bf16_dot_product_accumulator_top: BF16 dot product with FP32 lane sums
// Top level joining the input front end, the word queue and the arithmetic
// back end with its sixteen lane accumulators.
// ----------------------------------------------------------------------------
// Each input word carries two BF16 activation and weight pairs for one of
// sixteen lanes. Activations at or beyond the reduction length are replaced
// by zero, then the high product and after it the low product are added to
// the lane's FP32 accumulator, each add rounded to nearest even with
// denormals flushed to zero. A word with first set starts the lane from
// zero, and a word with last set returns the lane number and its sum on the
// output channel. Input words are taken into a four-word queue as long as
// it has room, so the input side keeps flowing while the back end works.
// The back end runs both products of a word through one shared multiply-add
// unit in four steps each (multiply, align and add, normalize, round), so a
// word occupies it from load to write-back, skipping steps on a zero
// product, on infinite or NaN values or on an add that cancels; the shared
// unit sets the sustained rate. The finished sum sits in an output register,
// and the back end only waits on it when a second sum is ready before the
// first is taken. The user writes the reduction length through cfg_we and
// cfg_data while the block is idle, unenforced by the block; it resets to 4096.
// ----------------------------------------------------------------------------
`default_nettype none

module bf16_dot_product_accumulator_top
  import bdpa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [RLEN_W-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [15:0]       act_lo,
  input  wire logic [15:0]       act_hi,
  input  wire logic [15:0]       wgt_lo,
  input  wire logic [15:0]       wgt_hi,
  input  wire logic [3:0]        lane,
  input  wire logic [15:0]       pos,
  input  wire logic              first,
  input  wire logic              last,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [3:0]             out_lane,
  output logic [31:0]            sum_bits
);

  item_t push_item;
  item_t head_item;
  logic  push;
  logic  full;
  logic  pop;
  logic  empty;

  // Front end: register for the reduction length and activation masking.
  bdpa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .act_lo   (act_lo),
    .act_hi   (act_hi),
    .wgt_lo   (wgt_lo),
    .wgt_hi   (wgt_hi),
    .lane     (lane),
    .pos      (pos),
    .first    (first),
    .last     (last),
    .q_full   (full),
    .q_push   (push),
    .q_item   (push_item)
  );

  // Queue that decouples acceptance from the arithmetic.
  bdpa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head_item)
  );

  // Back end: lane accumulators, shared multiply-add and output register.
  bdpa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (empty),
    .q_head    (head_item),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_lane  (out_lane),
    .sum_bits  (sum_bits)
  );

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: BF16 dot product with FP32 lane sums
// Drives words with random gaps and output stalls, predicts every lane sum
// with a bit-exact FP32 multiply-add model and checks each returned sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import bdpa_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  // Enough quiet cycles to drain the four-word queue through the back end.
  localparam int DRAIN_CYCLES = 120;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [RLEN_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [15:0]       act_lo = '0, act_hi = '0, wgt_lo = '0, wgt_hi = '0;
  logic [3:0]        lane = '0;
  logic [15:0]       pos = '0;
  logic              first = 1'b0, last = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [3:0]        out_lane;
  logic [31:0]       sum_bits;

  bf16_dot_product_accumulator_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .act_lo(act_lo), .act_hi(act_hi), .wgt_lo(wgt_lo), .wgt_hi(wgt_hi),
    .lane(lane), .pos(pos), .first(first), .last(last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_lane(out_lane), .sum_bits(sum_bits)
  );

  // The clock has a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typedef struct {
    logic [3:0]  lane_no;
    logic [31:0] sum;
  } lane_sum_t;

  // One row of the directed table. A row either writes the reduction length
  // or sends one word; a typed sum is used only where the row marks it known.
  typedef struct {
    bit          is_cfg;
    logic [16:0] rlen;
    logic [15:0] alo, ahi, wlo, whi;
    logic [3:0]  ln;
    logic [15:0] p;
    bit          f, l;
    bit          known;
    logic [31:0] sum;
  } dir_row_t;

  lane_sum_t   pending_sums[$];
  logic [31:0] model_acc[LANES];
  logic [16:0] model_rlen;
  int          errors = 0;
  int          cycles = 0;
  bit          steady = 1'b0;

  // ---------------------------------------------------------------------------
  // FP32 arithmetic predictor.
  // ---------------------------------------------------------------------------

  function automatic int msb_index(logic [63:0] v);
    int p;
    p = 0;
    for (int i = 0; i < 64; i++)
      if (v[i]) p = i;
    return p;
  endfunction

  // Rounds (-1)^s * r * 2^e to FP32, nearest even, flushing tiny results.
  function automatic logic [31:0] fp32_round(bit s, logic [63:0] r, int e);
    int p, sh, be;
    logic [63:0] q, rem, half;
    p = msb_index(r);
    sh = p - 23;
    if (sh > 0) begin
      rem = r & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      q = r >> sh;
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      if ((q >> 24) != 0) begin
        q = q >> 1;
        sh++;
      end
    end else begin
      q = r << (-sh);
    end
    be = e + sh + 150;
    if (be >= 255) return {s, INF_MAG};
    if (be <= 0) return {s, 31'd0};
    return {s, be[7:0], q[22:0]};
  endfunction

  // Adds the exact product a*w to acc with a single rounding.
  function automatic logic [31:0] fused_add(logic [31:0] acc, logic [15:0] a,
                                            logic [15:0] w);
    logic [7:0]  ea, ew, ec;
    logic [6:0]  fa, fw;
    logic [22:0] fc;
    bit          sp, sc, sx, sy;
    fclass_t     pc, cc;
    logic [63:0] mp, mc, mx, my, lost;
    int          xp, xc, ex, ey, d, k;
    ea = a[14:7]; fa = a[6:0];
    ew = w[14:7]; fw = w[6:0];
    sp = a[15] ^ w[15];
    ec = acc[30:23]; fc = acc[22:0]; sc = acc[31];
    if ((ea == 8'hFF && fa != 0) || (ew == 8'hFF && fw != 0) ||
        (ea == 8'hFF && ew == 0) || (ew == 8'hFF && ea == 0))
      pc = CL_NAN;
    else if (ea == 8'hFF || ew == 8'hFF)
      pc = CL_INF;
    else if (ea == 0 || ew == 0)
      pc = CL_ZERO;
    else
      pc = CL_NORM;
    if (ec == 8'hFF) cc = (fc != 0) ? CL_NAN : CL_INF;
    else if (ec == 0) cc = CL_ZERO;
    else cc = CL_NORM;

    if (pc == CL_NAN || cc == CL_NAN) return QNAN_BITS;
    if (pc == CL_INF && cc == CL_INF) return (sp == sc) ? acc : QNAN_BITS;
    if (pc == CL_INF) return {sp, INF_MAG};
    if (cc == CL_INF) return acc;
    if (pc == CL_ZERO) begin
      if (cc == CL_ZERO) return {sp & sc, 31'd0};
      return acc;
    end

    mp = {57'd1, fa} * {57'd1, fw};
    xp = int'(ea) + int'(ew) - 268;
    if (cc == CL_ZERO) return fp32_round(sp, mp, xp);

    mc = {41'd1, fc};
    xc = int'(ec) - 150;
    k = 40 - msb_index(mp);
    mp = mp << k;
    xp = xp - k;
    mc = mc << 17;
    xc = xc - 17;
    if (xc > xp || (xc == xp && mc >= mp)) begin
      mx = mc; ex = xc; sx = sc;
      my = mp; ey = xp; sy = sp;
    end else begin
      mx = mp; ex = xp; sx = sp;
      my = mc; ey = xc; sy = sc;
    end
    d = ex - ey;
    if (d > 45) begin
      my = 64'd1;
    end else if (d > 0) begin
      lost = my & ((64'd1 << d) - 64'd1);
      my = (my >> d) | ((lost != 0) ? 64'd1 : 64'd0);
    end
    if (sx == sy) return fp32_round(sx, mx + my, ex);
    if (mx == my) return 32'd0;
    return fp32_round(sx, mx - my, ex);
  endfunction

  // Applies one accepted word to the model lanes and returns the lane sum.
  function automatic logic [31:0] lane_update(logic [15:0] alo, logic [15:0] ahi,
                                              logic [15:0] wlo, logic [15:0] whi,
                                              logic [3:0] ln, logic [15:0] p,
                                              bit f);
    logic [31:0] acc;
    if ({1'b0, p} >= model_rlen) alo = '0;
    if ({1'b0, p} + 17'd1 >= model_rlen) ahi = '0;
    acc = f ? 32'd0 : model_acc[ln];
    acc = fused_add(acc, ahi, whi);
    acc = fused_add(acc, alo, wlo);
    model_acc[ln] = acc;
    return acc;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------

  // Sends one word, then updates the model once it has been taken and records the expected sum for a last word.
  task automatic send_word(logic [15:0] alo, logic [15:0] ahi, logic [15:0] wlo,
                           logic [15:0] whi, logic [3:0] ln, logic [15:0] p,
                           bit f, bit l, bit known, logic [31:0] typed_sum);
    logic [31:0] s;
    lane_sum_t   e;
    // Outside the steady phase, each cycle ahead of a word idles with about one
    // chance in five, so gaps of varied length land on every phase of the back end.
    while (!steady && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    act_lo <= alo; act_hi <= ahi; wgt_lo <= wlo; wgt_hi <= whi;
    lane <= ln; pos <= p; first <= f; last <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    s = lane_update(alo, ahi, wlo, whi, ln, p, f);
    if (l) begin
      e.lane_no = ln;
      e.sum = known ? typed_sum : s;
      pending_sums.push_back(e);
    end
  endtask

  // Register writes happen only with the block drained: every sum back and
  // time for a trailing word without last to finish in the back end.
  task automatic write_reduce_len(logic [16:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_rlen = v;
  endtask

  // Mostly moderate normal values so sums stay finite, plus the specials.
  function automatic logic [15:0] pick_bf16();
    int r;
    r = $urandom_range(99);
    if (r < 65) return {1'($urandom), 8'($urandom_range(134, 118)), 7'($urandom)};
    if (r < 80) return 16'($urandom);
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7F80;
      3: return 16'hFF80;
      4: return 16'h7FC0;
      5: return {1'($urandom), 8'h00, 7'($urandom)};
      6: return 16'h7F7F;
      default: return 16'h0080;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stalls and the checker.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 21);
    end
  end

  always @(posedge clk) begin
    lane_sum_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected sum: lane %0d sum %h", $realtime, out_lane, sum_bits);
        errors++;
      end else begin
        e = pending_sums.pop_front();
        if (out_lane !== e.lane_no) begin
          $display("%0t: out_lane expected %0d actual %0d", $realtime, e.lane_no,
                   out_lane);
          errors++;
        end
        if (sum_bits !== e.sum) begin
          $display("%0t: sum_bits expected %h actual %h", $realtime, e.sum, sum_bits);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------

  dir_row_t dir_rows[23];

  initial begin
    int          sent;
    int          seq_len;
    logic [3:0]  ln;
    logic [16:0] p;
    logic [16:0] rl;

    // Directed rows: simple sums, NaN, zero times infinity, overflow,
    // flushed tiny products, denormal inputs, exact cancellation, the mask at
    // the reduction length (also against an infinite weight and at odd pos),
    // interleaved lanes, infinity minus infinity, and the length extremes.
    dir_rows = '{
      '{0, 0, 16'h4000, 16'h3F80, 16'h4000, 16'h3F80, 0, 0, 1, 1, 1, 32'h40A0_0000},
      '{0, 0, 16'h0000, 16'h7FC1, 16'h0000, 16'h3F80, 1, 0, 1, 1, 1, QNAN_BITS},
      '{0, 0, 16'h0000, 16'h7F80, 16'h0000, 16'h0000, 2, 0, 1, 1, 1, QNAN_BITS},
      '{0, 0, 16'h3F80, 16'h7F7F, 16'h3F80, 16'h7F7F, 3, 0, 1, 1, 1, 32'h7F80_0000},
      '{0, 0, 16'h0000, 16'h0080, 16'h0000, 16'h0080, 4, 0, 1, 1, 1, 32'h0},
      '{0, 0, 16'h0001, 16'h0001, 16'h3F80, 16'h3F80, 5, 0, 1, 1, 1, 32'h0},
      '{0, 0, 16'hBF80, 16'h3F80, 16'h3F80, 16'h3F80, 6, 0, 1, 1, 1, 32'h0},
      '{0, 0, 16'h0000, 16'h7F80, 16'h0000, 16'h7F80, 7, 4096, 1, 1, 1, QNAN_BITS},
      '{0, 0, 16'h3F80, 16'h4000, 16'h3F80, 16'h4000, 8, 4095, 1, 1, 1, 32'h3F80_0000},
      '{0, 0, 16'h3E20, 16'hC123, 16'h4091, 16'h3FAB, 15, 10, 1, 0, 0, 32'h0},
      '{0, 0, 16'h4255, 16'h3C01, 16'hBF01, 16'h42F0, 15, 12, 0, 0, 0, 32'h0},
      '{0, 0, 16'hC0A0, 16'h3F33, 16'h4111, 16'hBE99, 9, 0, 1, 1, 0, 32'h0},
      '{0, 0, 16'h3A7F, 16'hC080, 16'h3D00, 16'h3F81, 15, 14, 0, 1, 0, 32'h0},
      '{0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10, 16'hFFFF, 1, 1, 1, QNAN_BITS},
      '{0, 0, 16'h0000, 16'h7F80, 16'h0000, 16'h3F80, 11, 0, 1, 0, 0, 32'h0},
      '{0, 0, 16'h0000, 16'hFF80, 16'h0000, 16'h3F80, 11, 2, 0, 1, 1, QNAN_BITS},
      '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0},
      '{0, 0, 16'h3F80, 16'h3F80, 16'h3F80, 16'h3F80, 12, 0, 1, 1, 1, 32'h0},
      '{1, 17'd65536, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0},
      '{0, 0, 16'h3F80, 16'h3F80, 16'h4000, 16'h3F80, 13, 16'hFFFE, 1, 1, 1,
        32'h4040_0000},
      '{1, 17'd1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0},
      '{0, 0, 16'h4040, 16'h3F80, 16'h3F80, 16'h3F80, 14, 0, 1, 1, 1, 32'h4040_0000},
      '{0, 0, 16'h3F80, 16'h3F80, 16'h3F80, 16'h3F80, 0, 0, 0, 1, 0, 32'h0}
    };

    for (int i = 0; i < LANES; i++) model_acc[i] = 32'd0;
    model_rlen = REDUCE_LEN_RESET;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_reduce_len(dir_rows[i].rlen);
      end else begin
        send_word(dir_rows[i].alo, dir_rows[i].ahi, dir_rows[i].wlo, dir_rows[i].whi,
                  dir_rows[i].ln, dir_rows[i].p, dir_rows[i].f, dir_rows[i].l,
                  dir_rows[i].known, dir_rows[i].sum);
      end
    end

    // Random phases, each under its own reduction length. Most words form
    // well-ordered runs on one lane (first, rising even pos, last), started
    // near the length so the mask boundary is crossed; the rest is noise.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: rl = 17'd65536;
        1: rl = 17'($urandom_range(200, 2));
        2: rl = 17'd4096;
        3: rl = 17'd1;
        default: rl = 17'($urandom_range(65536, 1));
      endcase
      write_reduce_len(rl);
      steady = (ph == 2);
      sent = 0;
      while (sent < 220) begin
        if ($urandom_range(99) < 12) begin
          send_word(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    4'($urandom), 16'($urandom), 1'($urandom), 1'($urandom), 0, 0);
          sent++;
        end else begin
          ln = 4'($urandom);
          seq_len = $urandom_range(8, 1);
          p = (rl > 17'd8) ? rl - 17'($urandom_range(2 * seq_len + 4, 0)) : 17'd0;
          p[0] = 1'b0;
          for (int w = 0; w < seq_len; w++) begin
            send_word(pick_bf16(), pick_bf16(), pick_bf16(), pick_bf16(), ln, p[15:0],
                      w == 0, w == seq_len - 1, 0, 0);
            p = p + 17'd2;
            sent++;
          end
        end
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/bdpa_pkg.sv
hdl/bdpa_front.sv
hdl/bdpa_queue.sv
hdl/bdpa_back.sv
hdl/bf16_dot_product_accumulator_top.sv
tb/sv/testbench.sv
